/* design/cnvr_pkg.sv */
// Shared types, constants and helper functions for the convolution engine.
// Used by every module of the block but the RAM, and by its port checker.
package cnvr_pkg;

  localparam int MAX_KERNELS_DEF  = 8;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int MAX_TAPS_DEF     = 5;
  localparam int MAX_DIM_DEF      = 32;

  localparam int DATA_W = 16;
  localparam int BIAS_W = 32;
  localparam int RES_W  = 32;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    FUNC_WEIGHT  = 2'd0,
    FUNC_BIAS    = 2'd1,
    FUNC_SAMPLE  = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_KERNEL_COUNT  = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_TAP_SIZE      = 3'd2,
    REG_IN_HEIGHT     = 3'd3,
    REG_IN_WIDTH      = 3'd4,
    REG_RELU_ENABLE   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] kernel_count;
    logic [3:0] channel_count;
    logic [2:0] tap_size;
    logic [5:0] in_height;
    logic [5:0] in_width;
    logic       relu_enable;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic bias_add;
    logic finish;
    logic fail;
  } mac_ctrl_t;

  // Number of bits that index depth entries, at least one.
  function automatic int addr_w(input int depth);
    int w;
    w = 1;
    while ((1 << w) < depth) w++;
    return w;
  endfunction

endpackage

/* design/cnvr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; width and depth come from parameters.
module cnvr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/cnvr_mac.sv */
// Shared multiply-accumulate unit with bias add, ReLU, clamping and result registers.
// Depends on cnvr_pkg for the control struct and the datapath widths.
module cnvr_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  cnvr_pkg::mac_ctrl_t             ctrl,
  input  logic                            relu_enable,
  input  logic [cnvr_pkg::DATA_W-1:0]     sample,
  input  logic [cnvr_pkg::DATA_W-1:0]     weight,
  input  logic [cnvr_pkg::BIAS_W-1:0]     bias,
  output logic                            done,
  output logic [cnvr_pkg::RES_W-1:0]      conv_result,
  output logic                            status,
  output logic                            saturated
);
  import cnvr_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_v;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  relu_val;
  logic                     in_range;

  assign relu_val = (relu_enable && acc[ACC_W-1]) ? '0 : acc;
  assign in_range = (relu_val[ACC_W-1:RES_W-1] == '0) || (relu_val[ACC_W-1:RES_W-1] == '1);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= $signed(sample) * $signed(weight);
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end else if (ctrl.bias_add) begin
      acc <= acc + {{(ACC_W-BIAS_W){bias[BIAS_W-1]}}, bias};
    end
    if (ctrl.fail) begin
      conv_result <= '0;
      status      <= 1'b1;
      saturated   <= 1'b0;
    end else if (ctrl.finish) begin
      status    <= 1'b0;
      saturated <= !in_range;
      if (in_range) begin
        conv_result <= relu_val[RES_W-1:0];
      end else if (relu_val[ACC_W-1]) begin
        conv_result <= {1'b1, {(RES_W-1){1'b0}}};
      end else begin
        conv_result <= {1'b0, {(RES_W-1){1'b1}}};
      end
    end
    if (rst) begin
      prod_v <= 1'b0;
      done   <= 1'b0;
    end else begin
      prod_v <= ctrl.mul_en && !ctrl.clear;
      done   <= ctrl.fail || ctrl.finish;
    end
  end

endmodule

/* design/cnvr_seq.sv */
// Sequencer that checks a compute word, walks channels and taps, and drives the MAC unit.
// Depends on cnvr_pkg for the configuration and control structs.
module cnvr_seq #(
  parameter int MAX_KERNELS  = cnvr_pkg::MAX_KERNELS_DEF,
  parameter int MAX_CHANNELS = cnvr_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_TAPS     = cnvr_pkg::MAX_TAPS_DEF,
  parameter int MAX_DIM      = cnvr_pkg::MAX_DIM_DEF,
  localparam int S_AW = cnvr_pkg::addr_w(MAX_CHANNELS * MAX_DIM * MAX_DIM),
  localparam int W_AW = cnvr_pkg::addr_w(MAX_KERNELS * MAX_CHANNELS * MAX_TAPS * MAX_TAPS),
  localparam int B_AW = cnvr_pkg::addr_w(MAX_KERNELS * MAX_DIM * MAX_DIM)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [2:0]          kernel_index,
  input  logic [4:0]          row,
  input  logic [4:0]          col,
  input  cnvr_pkg::cfg_t      cfg,
  output logic                busy,
  output cnvr_pkg::mac_ctrl_t ctrl,
  output logic [S_AW-1:0]     s_raddr,
  output logic [W_AW-1:0]     w_raddr,
  output logic [B_AW-1:0]     b_raddr
);
  import cnvr_pkg::*;

  localparam int CH_W  = addr_w(MAX_CHANNELS);
  localparam int TAP_W = addr_w(MAX_TAPS);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RUN, S_DRAIN_A, S_DRAIN_B, S_BIAS, S_FINISH
  } state_t;

  state_t           state;
  logic [2:0]       k;
  logic [4:0]       r;
  logic [4:0]       c;
  logic [CH_W-1:0]  ci;
  logic [TAP_W-1:0] ty;
  logic [TAP_W-1:0] tx;
  logic             rd_v;
  logic             bad;
  logic             x_last;
  logic             y_last;
  logic             c_last;
  logic [31:0]      s_full;
  logic [31:0]      w_full;
  logic [31:0]      b_full;
  int               kc, cc, ts, ih, iw;

  always_comb begin
    kc  = int'(cfg.kernel_count);
    cc  = int'(cfg.channel_count);
    ts  = int'(cfg.tap_size);
    ih  = int'(cfg.in_height);
    iw  = int'(cfg.in_width);
    bad = (kc < 1) || (kc > MAX_KERNELS) || (cc < 1) || (cc > MAX_CHANNELS) ||
          (ts < 1) || (ts > MAX_TAPS) || (ih < 1) || (ih > MAX_DIM) ||
          (iw < 1) || (iw > MAX_DIM) || (ts > ih) || (ts > iw) ||
          (int'(k) >= kc) || (int'(r) > ih - ts) || (int'(c) > iw - ts);
  end

  assign x_last = (int'(tx) == int'(cfg.tap_size) - 1);
  assign y_last = (int'(ty) == int'(cfg.tap_size) - 1);
  assign c_last = (int'(ci) == int'(cfg.channel_count) - 1);

  assign s_full = 32'((int'(ci) * MAX_DIM + int'(r) + int'(ty)) * MAX_DIM + int'(c) + int'(tx));
  assign w_full = 32'(((int'(k) * MAX_CHANNELS + int'(ci)) * MAX_TAPS + int'(ty)) * MAX_TAPS
                      + int'(tx));
  assign b_full = 32'((int'(k) * MAX_DIM + int'(r)) * MAX_DIM + int'(c));
  assign s_raddr = s_full[S_AW-1:0];
  assign w_raddr = w_full[W_AW-1:0];
  assign b_raddr = b_full[B_AW-1:0];

  assign busy          = (state != S_IDLE);
  assign ctrl.clear    = (state == S_CHECK);
  assign ctrl.mul_en   = rd_v;
  assign ctrl.bias_add = (state == S_BIAS);
  assign ctrl.finish   = (state == S_FINISH);
  assign ctrl.fail     = (state == S_CHECK) && bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= (state == S_RUN);
      case (state)
        S_IDLE: begin
          if (go) begin
            k     <= kernel_index;
            r     <= row;
            c     <= col;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          ci    <= '0;
          ty    <= '0;
          tx    <= '0;
          state <= bad ? S_IDLE : S_RUN;
        end
        S_RUN: begin
          if (!x_last) begin
            tx <= tx + 1'b1;
          end else begin
            tx <= '0;
            if (!y_last) begin
              ty <= ty + 1'b1;
            end else begin
              ty <= '0;
              if (!c_last) begin
                ci <= ci + 1'b1;
              end else begin
                state <= S_DRAIN_A;
              end
            end
          end
        end
        S_DRAIN_A: state <= S_DRAIN_B;
        S_DRAIN_B: state <= S_BIAS;
        S_BIAS:    state <= S_FINISH;
        S_FINISH:  state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/conv2d_valid_multichannel_relu.sv */
// Compute word: busy from check to finish state; done strobes the cycle after busy ends.
// A compute word that fails the size or position check returns to idle from the check state.
// Store writes leave busy low. One shared multiplier sets the rate.
// Reset is synchronous and restores the register defaults; the stores keep their contents.
// The result is shown for exactly one cycle and cannot be held off.
// Depends on cnvr_pkg, cnvr_ram, cnvr_seq and cnvr_mac.
module conv2d_valid_multichannel_relu #(
  parameter int MAX_KERNELS  = cnvr_pkg::MAX_KERNELS_DEF,
  parameter int MAX_CHANNELS = cnvr_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_TAPS     = cnvr_pkg::MAX_TAPS_DEF,
  parameter int MAX_DIM      = cnvr_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cnvr_pkg::APB_AW-1:0]   paddr,
  input  logic [cnvr_pkg::APB_DW-1:0]   pwdata,
  output logic [cnvr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [2:0]                    kernel_index,
  input  logic [2:0]                    channel,
  input  logic [4:0]                    row,
  input  logic [4:0]                    col,
  input  logic [15:0]                   data_word,
  input  logic [31:0]                   bias_word,
  output logic                          done,
  output logic [31:0]                   conv_result,
  output logic                          status,
  output logic                          saturated
);
  import cnvr_pkg::*;

  localparam int S_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
  localparam int W_DEPTH = MAX_KERNELS * MAX_CHANNELS * MAX_TAPS * MAX_TAPS;
  localparam int B_DEPTH = MAX_KERNELS * MAX_DIM * MAX_DIM;
  localparam int S_AW    = addr_w(S_DEPTH);
  localparam int W_AW    = addr_w(W_DEPTH);
  localparam int B_AW    = addr_w(B_DEPTH);

  cfg_t             cfg;
  mac_ctrl_t        ctrl;
  reg_idx_t         reg_idx;
  logic             accept;
  logic             go;
  logic             s_we, w_we, b_we;
  logic [31:0]      s_wfull, w_wfull, b_wfull;
  logic [S_AW-1:0]  s_raddr;
  logic [W_AW-1:0]  w_raddr;
  logic [B_AW-1:0]  b_raddr;
  logic [DATA_W-1:0] s_rdata;
  logic [DATA_W-1:0] w_rdata;
  logic [BIAS_W-1:0] b_rdata;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_count  <= 4'd1;
      cfg.channel_count <= 4'd1;
      cfg.tap_size      <= 3'd3;
      cfg.in_height     <= 6'd32;
      cfg.in_width      <= 6'd32;
      cfg.relu_enable   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_KERNEL_COUNT:  cfg.kernel_count  <= pwdata[3:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[3:0];
        REG_TAP_SIZE:      cfg.tap_size      <= pwdata[2:0];
        REG_IN_HEIGHT:     cfg.in_height     <= pwdata[5:0];
        REG_IN_WIDTH:      cfg.in_width      <= pwdata[5:0];
        REG_RELU_ENABLE:   cfg.relu_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KERNEL_COUNT:  prdata = 32'(cfg.kernel_count);
      REG_CHANNEL_COUNT: prdata = 32'(cfg.channel_count);
      REG_TAP_SIZE:      prdata = 32'(cfg.tap_size);
      REG_IN_HEIGHT:     prdata = 32'(cfg.in_height);
      REG_IN_WIDTH:      prdata = 32'(cfg.in_width);
      REG_RELU_ENABLE:   prdata = 32'(cfg.relu_enable);
      default:           prdata = '0;
    endcase
  end

  assign accept = start && !busy;
  assign go     = accept && (func_t'(func) == FUNC_COMPUTE);

  assign w_we = accept && (func_t'(func) == FUNC_WEIGHT) &&
                (int'(kernel_index) < MAX_KERNELS) && (int'(channel) < MAX_CHANNELS) &&
                (int'(row) < MAX_TAPS) && (int'(col) < MAX_TAPS);
  assign b_we = accept && (func_t'(func) == FUNC_BIAS) &&
                (int'(kernel_index) < MAX_KERNELS) && (int'(row) < MAX_DIM) &&
                (int'(col) < MAX_DIM);
  assign s_we = accept && (func_t'(func) == FUNC_SAMPLE) &&
                (int'(channel) < MAX_CHANNELS) && (int'(row) < MAX_DIM) &&
                (int'(col) < MAX_DIM);

  assign w_wfull = 32'(((int'(kernel_index) * MAX_CHANNELS + int'(channel)) * MAX_TAPS
                        + int'(row)) * MAX_TAPS + int'(col));
  assign b_wfull = 32'((int'(kernel_index) * MAX_DIM + int'(row)) * MAX_DIM + int'(col));
  assign s_wfull = 32'((int'(channel) * MAX_DIM + int'(row)) * MAX_DIM + int'(col));

  cnvr_ram #(.WIDTH(DATA_W), .DEPTH(S_DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_wfull[S_AW-1:0]),
    .wdata (data_word),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  cnvr_ram #(.WIDTH(DATA_W), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_wfull[W_AW-1:0]),
    .wdata (data_word),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  cnvr_ram #(.WIDTH(BIAS_W), .DEPTH(B_DEPTH)) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_wfull[B_AW-1:0]),
    .wdata (bias_word),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  cnvr_seq #(
    .MAX_KERNELS  (MAX_KERNELS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_TAPS     (MAX_TAPS),
    .MAX_DIM      (MAX_DIM)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .kernel_index (kernel_index),
    .row          (row),
    .col          (col),
    .cfg          (cfg),
    .busy         (busy),
    .ctrl         (ctrl),
    .s_raddr      (s_raddr),
    .w_raddr      (w_raddr),
    .b_raddr      (b_raddr)
  );

  cnvr_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .relu_enable (cfg.relu_enable),
    .sample      (s_rdata),
    .weight      (w_rdata),
    .bias        (b_rdata),
    .done        (done),
    .conv_result (conv_result),
    .status      (status),
    .saturated   (saturated)
  );

endmodule

/* design/cnvr_check.sv */
// Port-level checker for the convolution engine and the bind that attaches it.
// Depends on cnvr_pkg and on the top level's port names.
module cnvr_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func,
  input logic        done,
  input logic [31:0] conv_result,
  input logic        status,
  input logic        saturated
);
  import cnvr_pkg::*;

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (func_t'(func) != FUNC_COMPUTE) |=> !busy && !done)
    else $error("A store write word made the block busy or produced a result.");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (func_t'(func) == FUNC_COMPUTE) |=> busy)
    else $error("A compute word did not make the block busy.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $fell(busy))
    else $error("A result appeared while busy or without a finished compute word.");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    done && status |-> (conv_result == '0) && !saturated)
    else $error("A rejected compute word returned a nonzero result.");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> (conv_result == 32'h7fff_ffff) || (conv_result == 32'h8000_0000))
    else $error("A saturated result is not at a range bound.");

endmodule

bind conv2d_valid_multichannel_relu cnvr_check u_cnvr_check (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .func        (func),
  .done        (done),
  .conv_result (conv_result),
  .status      (status),
  .saturated   (saturated)
);

/* sim/tb_top.sv */
// Self-checking testbench for conv2d_valid_multichannel_relu: store writes and compute words
// are sent with random gaps, and every compute result is checked against a behavioral model.
// Depends on cnvr_pkg and the conv2d_valid_multichannel_relu RTL.
module tb_top;
  import cnvr_pkg::*;

  localparam int SAMPLE_DEPTH  = MAX_CHANNELS_DEF * MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int WEIGHT_DEPTH  = MAX_KERNELS_DEF * MAX_CHANNELS_DEF * MAX_TAPS_DEF * MAX_TAPS_DEF;
  localparam int BIAS_DEPTH    = MAX_KERNELS_DEF * MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int ITEM_TARGET   = 1650;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 250;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam logic [2:0] REG_SPARE = 3'd6;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  reg_sel;
    logic [31:0] reg_data;
    func_t       fn;
    logic [2:0]  kern;
    logic [2:0]  chan;
    logic [4:0]  r;
    logic [4:0]  c;
    logic [15:0] data;
    logic [31:0] bias;
    logic [7:0]  hold;
  } tb_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic        status;
    logic        sat;
  } conv_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func = '0;
  logic [2:0] kernel_index = '0;
  logic [2:0] channel = '0;
  logic [4:0] row = '0;
  logic [4:0] col = '0;
  logic [15:0] data_word = '0;
  logic [31:0] bias_word = '0;
  logic done;
  logic [31:0] conv_result;
  logic status;
  logic saturated;

  conv2d_valid_multichannel_relu dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .func(func), .kernel_index(kernel_index), .channel(channel), .row(row), .col(col),
    .data_word(data_word), .bias_word(bias_word),
    .done(done), .conv_result(conv_result), .status(status), .saturated(saturated)
  );

  always #5 clk = ~clk;

  localparam cfg_t CFG_DEFAULT = '{kernel_count: 4'd1, channel_count: 4'd1, tap_size: 3'd3,
                                   in_height: 6'd32, in_width: 6'd32, relu_enable: 1'b1};

  // Mirror of the block used for prediction.
  cfg_t model_cfg = CFG_DEFAULT;
  bit signed [15:0] sample_mem [SAMPLE_DEPTH];
  bit signed [15:0] weight_mem [WEIGHT_DEPTH];
  bit signed [31:0] bias_mem [BIAS_DEPTH];
  conv_word_t conv_results_due [$];

  // Generator state, kept as the stimulus is queued.
  cfg_t gen_cfg = CFG_DEFAULT;
  bit sample_loaded [SAMPLE_DEPTH];
  bit weight_loaded [WEIGHT_DEPTH];
  bit bias_loaded [BIAS_DEPTH];
  tb_word_t words_to_send [$];
  int cmd_total = 0;
  int data_style = 0;
  int gap_style = 0;

  tb_word_t cur_word = '0;
  bit word_loaded = 1'b0;
  int apb_step = 0;
  int hold_left = 0;
  int settle_left = SETTLE_CYCLES;
  bit nx_start, nx_psel, nx_penable;
  int error_count = 0;
  int cycle_count = 0;

  function automatic int sample_idx(int ch, int r, int c);
    return (ch * MAX_DIM_DEF + r) * MAX_DIM_DEF + c;
  endfunction

  function automatic int weight_idx(int k, int ch, int y, int x);
    return ((k * MAX_CHANNELS_DEF + ch) * MAX_TAPS_DEF + y) * MAX_TAPS_DEF + x;
  endfunction

  function automatic int bias_idx(int k, int r, int c);
    return (k * MAX_DIM_DEF + r) * MAX_DIM_DEF + c;
  endfunction

  function automatic cfg_t with_reg(cfg_t cf, logic [2:0] idx, logic [31:0] d);
    case (idx)
      REG_KERNEL_COUNT:  cf.kernel_count = d[3:0];
      REG_CHANNEL_COUNT: cf.channel_count = d[3:0];
      REG_TAP_SIZE:      cf.tap_size = d[2:0];
      REG_IN_HEIGHT:     cf.in_height = d[5:0];
      REG_IN_WIDTH:      cf.in_width = d[5:0];
      REG_RELU_ENABLE:   cf.relu_enable = d[0];
      default: ;
    endcase
    return cf;
  endfunction

  function automatic bit conv_rejected(cfg_t cf, int k, int r, int c);
    int kc, cc, ts, h, w;
    kc = cf.kernel_count;
    cc = cf.channel_count;
    ts = cf.tap_size;
    h = cf.in_height;
    w = cf.in_width;
    if (kc < 1 || kc > MAX_KERNELS_DEF) return 1'b1;
    if (cc < 1 || cc > MAX_CHANNELS_DEF) return 1'b1;
    if (ts < 1 || ts > MAX_TAPS_DEF) return 1'b1;
    if (h < 1 || h > MAX_DIM_DEF) return 1'b1;
    if (w < 1 || w > MAX_DIM_DEF) return 1'b1;
    if (ts > h || ts > w) return 1'b1;
    if (k >= kc) return 1'b1;
    if (r > h - ts) return 1'b1;
    if (c > w - ts) return 1'b1;
    return 1'b0;
  endfunction

  function automatic conv_word_t predict_conv(int k, int r, int c);
    conv_word_t res;
    longint acc;
    res = '0;
    if (conv_rejected(model_cfg, k, r, c)) begin
      res.status = 1'b1;
      return res;
    end
    acc = 0;
    for (int ci = 0; ci < model_cfg.channel_count; ci++)
      for (int y = 0; y < model_cfg.tap_size; y++)
        for (int x = 0; x < model_cfg.tap_size; x++)
          acc += longint'(sample_mem[sample_idx(ci, r + y, c + x)]) *
                 longint'(weight_mem[weight_idx(k, ci, y, x)]);
    acc += longint'(bias_mem[bias_idx(k, r, c)]);
    if (model_cfg.relu_enable && acc < 0) acc = 0;
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = acc[31:0];
    return res;
  endfunction

  function automatic void predict_word(tb_word_t w);
    case (w.fn)
      FUNC_WEIGHT: begin
        if (w.kern < MAX_KERNELS_DEF && w.chan < MAX_CHANNELS_DEF &&
            w.r < MAX_TAPS_DEF && w.c < MAX_TAPS_DEF)
          weight_mem[weight_idx(w.kern, w.chan, w.r, w.c)] = w.data;
      end
      FUNC_BIAS: begin
        if (w.kern < MAX_KERNELS_DEF) bias_mem[bias_idx(w.kern, w.r, w.c)] = w.bias;
      end
      FUNC_SAMPLE: begin
        if (w.chan < MAX_CHANNELS_DEF) sample_mem[sample_idx(w.chan, w.r, w.c)] = w.data;
      end
      default: conv_results_due.push_back(predict_conv(w.kern, w.r, w.c));
    endcase
  endfunction

  function automatic logic [7:0] pick_hold();
    int roll;
    roll = $urandom_range(99, 0);
    case (gap_style)
      0: return 8'd0;
      1: begin
        if (roll < 60) return 8'd0;
        if (roll < 95) return 8'($urandom_range(3, 1));
        return 8'($urandom_range(60, 15));
      end
      default: begin
        if (roll < 20) return 8'd0;
        if (roll < 92) return 8'($urandom_range(6, 1));
        return 8'($urandom_range(120, 20));
      end
    endcase
  endfunction

  function automatic logic [15:0] fresh_data();
    logic [15:0] v;
    case (data_style)
      0: v = 16'($urandom());
      1: v = 16'($urandom_range(511, 0)) - 16'd256;
      default: begin
        case ($urandom_range(5, 0))
          0, 1, 2: v = 16'h8000;
          3, 4:    v = 16'h7FFF;
          default: v = 16'($urandom());
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] fresh_bias();
    logic [31:0] v;
    case (data_style)
      0: v = $urandom();
      1: v = 32'($urandom_range(1 << 20, 0)) - 32'(1 << 19);
      default: begin
        case ($urandom_range(3, 0))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0;
          default: v = $urandom();
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic void queue_cmd(func_t fn, int k, int ch, int r, int c,
                                    logic [15:0] d, logic [31:0] b);
    tb_word_t w;
    w = '0;
    w.fn = fn;
    w.kern = k[2:0];
    w.chan = ch[2:0];
    w.r = r[4:0];
    w.c = c[4:0];
    w.data = d;
    w.bias = b;
    w.hold = pick_hold();
    case (fn)
      FUNC_WEIGHT: if (r < MAX_TAPS_DEF && c < MAX_TAPS_DEF) weight_loaded[weight_idx(k, ch, r, c)] = 1'b1;
      FUNC_BIAS:   bias_loaded[bias_idx(k, r, c)] = 1'b1;
      FUNC_SAMPLE: sample_loaded[sample_idx(ch, r, c)] = 1'b1;
      default: ;
    endcase
    words_to_send.push_back(w);
    cmd_total++;
  endfunction

  // A valid compute word is preceded by writes of every entry it reads that is still empty.
  function automatic void queue_compute(int k, int r, int c);
    if (!conv_rejected(gen_cfg, k, r, c)) begin
      for (int ci = 0; ci < gen_cfg.channel_count; ci++)
        for (int y = 0; y < gen_cfg.tap_size; y++)
          for (int x = 0; x < gen_cfg.tap_size; x++) begin
            if (!sample_loaded[sample_idx(ci, r + y, c + x)] || $urandom_range(15, 0) == 0)
              queue_cmd(FUNC_SAMPLE, $urandom_range(7, 0), ci, r + y, c + x,
                        fresh_data(), $urandom());
            if (!weight_loaded[weight_idx(k, ci, y, x)] || $urandom_range(15, 0) == 0)
              queue_cmd(FUNC_WEIGHT, k, ci, y, x, fresh_data(), $urandom());
          end
      if (!bias_loaded[bias_idx(k, r, c)] || $urandom_range(7, 0) == 0)
        queue_cmd(FUNC_BIAS, k, $urandom_range(7, 0), r, c, 16'($urandom()), fresh_bias());
    end
    queue_cmd(FUNC_COMPUTE, k, $urandom_range(7, 0), r, c, 16'($urandom()), $urandom());
  endfunction

  function automatic void queue_reg(logic [2:0] idx, int value);
    tb_word_t w;
    w = '0;
    w.is_cfg = 1'b1;
    w.reg_sel = idx;
    w.reg_data = 32'(value);
    if ($urandom_range(3, 0) == 0) w.reg_data = w.reg_data | ($urandom() << 6);
    gen_cfg = with_reg(gen_cfg, w.reg_sel, w.reg_data);
    words_to_send.push_back(w);
  endfunction

  function automatic void queue_setting(int kc, int cc, int ts, int h, int w, int relu);
    queue_reg(REG_KERNEL_COUNT, kc);
    queue_reg(REG_CHANNEL_COUNT, cc);
    queue_reg(REG_TAP_SIZE, ts);
    queue_reg(REG_IN_HEIGHT, h);
    queue_reg(REG_IN_WIDTH, w);
    queue_reg(REG_RELU_ENABLE, relu);
    if ($urandom_range(3, 0) == 0) queue_reg(REG_SPARE + 3'($urandom_range(1, 0)), $urandom());
  endfunction

  function automatic void queue_random_write();
    int fn, r, c;
    fn = $urandom_range(2, 0);
    r = $urandom_range(31, 0);
    c = $urandom_range(31, 0);
    if (fn == 0 && $urandom_range(1, 0) == 1) begin
      r = $urandom_range(MAX_TAPS_DEF - 1, 0);
      c = $urandom_range(MAX_TAPS_DEF - 1, 0);
    end
    queue_cmd(func_t'(fn), $urandom_range(7, 0), $urandom_range(7, 0), r, c,
              fresh_data(), fresh_bias());
  endfunction

  function automatic void queue_random_phase();
    int kind, kc, cc, ts, h, w, n, roll;
    kind = $urandom_range(9, 0);
    data_style = $urandom_range(2, 0);
    gap_style = $urandom_range(2, 0);
    kc = $urandom_range(8, 1);
    cc = $urandom_range(3, 1);
    ts = $urandom_range(3, 1);
    h = $urandom_range(ts + 5, ts);
    w = $urandom_range(ts + 5, ts);
    if (kind == 0) begin
      case ($urandom_range(5, 0))
        0: kc = $urandom_range(1, 0) ? 0 : $urandom_range(15, 9);
        1: cc = $urandom_range(1, 0) ? 0 : $urandom_range(15, 9);
        2: ts = $urandom_range(2, 0) == 0 ? 0 : $urandom_range(7, 6);
        3: h = $urandom_range(1, 0) ? 0 : $urandom_range(63, 33);
        4: w = $urandom_range(1, 0) ? 0 : $urandom_range(63, 33);
        default: begin
          ts = $urandom_range(5, 2);
          if ($urandom_range(1, 0)) h = ts - 1;
          else w = ts - 1;
        end
      endcase
    end else if (kind == 1) begin
      kc = 1;
      cc = 1;
      ts = 1;
      h = 1;
      w = 1;
    end else if (kind == 2) begin
      cc = 1;
      ts = $urandom_range(2, 1);
      h = MAX_DIM_DEF;
      w = MAX_DIM_DEF;
    end
    queue_setting(kc, cc, ts, h, w, $urandom_range(1, 0));
    n = $urandom_range(40, 15);
    for (int a = 0; a < n; a++) begin
      roll = $urandom_range(99, 0);
      if (roll < 55 && !conv_rejected(gen_cfg, 0, 0, 0))
        queue_compute($urandom_range(gen_cfg.kernel_count - 1, 0),
                      $urandom_range(gen_cfg.in_height - gen_cfg.tap_size, 0),
                      $urandom_range(gen_cfg.in_width - gen_cfg.tap_size, 0));
      else if (roll < 70)
        queue_compute($urandom_range(7, 0), $urandom_range(31, 0), $urandom_range(31, 0));
      else
        queue_random_write();
    end
  endfunction

  function automatic void queue_opening_words();
    gap_style = 0;
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++) begin
        queue_cmd(FUNC_WEIGHT, 0, 0, y, x, 16'h8000, $urandom());
        queue_cmd(FUNC_SAMPLE, 0, 0, y, x, 16'h8000, $urandom());
      end
    queue_cmd(FUNC_BIAS, 0, 0, 0, 0, 16'h7FFF, 32'h7FFF_FFFF);
    queue_cmd(FUNC_COMPUTE, 0, 0, 0, 0, 16'h0, 32'h0);
    queue_cmd(FUNC_COMPUTE, 0, 0, 30, 0, 16'h0, 32'h0);
    queue_cmd(FUNC_COMPUTE, 0, 0, 0, 30, 16'h0, 32'h0);
    queue_cmd(FUNC_COMPUTE, 1, 0, 0, 0, 16'h0, 32'h0);
    queue_cmd(FUNC_WEIGHT, 7, 7, 31, 31, 16'hFFFF, 32'hFFFF_FFFF);
    queue_cmd(FUNC_COMPUTE, 0, 7, 0, 0, 16'hFFFF, 32'hFFFF_FFFF);

    // Largest kernel on the largest plane: one result at the far corner, then one just past the last valid row.
    data_style = 2;
    gap_style = 1;
    queue_setting(MAX_KERNELS_DEF, MAX_CHANNELS_DEF, MAX_TAPS_DEF, MAX_DIM_DEF, MAX_DIM_DEF, 0);
    queue_compute(MAX_KERNELS_DEF - 1, MAX_DIM_DEF - MAX_TAPS_DEF, MAX_DIM_DEF - MAX_TAPS_DEF);
    queue_compute(MAX_KERNELS_DEF - 1, MAX_DIM_DEF - MAX_TAPS_DEF + 1, 0);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      word_loaded = 1'b0;
      apb_step = 0;
      hold_left = 0;
      settle_left = SETTLE_CYCLES;
    end else begin
      if (start && !busy) begin
        predict_word(cur_word);
        word_loaded = 1'b0;
        settle_left = SETTLE_CYCLES;
      end
      if (apb_step == 2) begin
        model_cfg = with_reg(model_cfg, cur_word.reg_sel, cur_word.reg_data);
        word_loaded = 1'b0;
        apb_step = 0;
      end
      if (busy || conv_results_due.size() != 0) settle_left = SETTLE_CYCLES;
      else if (settle_left > 0) settle_left--;
      if (!word_loaded && words_to_send.size() != 0) begin
        cur_word = words_to_send.pop_front();
        word_loaded = 1'b1;
        hold_left = cur_word.hold;
      end
      nx_start = 1'b0;
      nx_psel = 1'b0;
      nx_penable = 1'b0;
      if (word_loaded) begin
        if (cur_word.is_cfg) begin
          if (apb_step == 1) begin
            nx_psel = 1'b1;
            nx_penable = 1'b1;
            apb_step = 2;
          end else if (settle_left == 0) begin
            nx_psel = 1'b1;
            apb_step = 1;
          end
        end else if (hold_left > 0) begin
          hold_left--;
        end else begin
          nx_start = 1'b1;
        end
      end
      start <= nx_start;
      psel <= nx_psel;
      penable <= nx_penable;
      pwrite <= nx_psel;
      paddr <= {cur_word.reg_sel, 2'b00};
      pwdata <= cur_word.reg_data;
      func <= cur_word.fn;
      kernel_index <= cur_word.kern;
      channel <= cur_word.chan;
      row <= cur_word.r;
      col <= cur_word.c;
      data_word <= cur_word.data;
      bias_word <= cur_word.bias;
    end
  end

  always @(posedge clk) begin
    conv_word_t due;
    if (!rst && done) begin
      if (conv_results_due.size() == 0) begin
        $display("%0t: result word with none expected: expected none, actual %h %b %b",
                 $time, conv_result, status, saturated);
        error_count++;
      end else begin
        due = conv_results_due.pop_front();
        if (conv_result !== due.value) report_mismatch("conv_result", due.value, conv_result);
        if (status !== due.status) report_mismatch("status", 32'(due.status), 32'(status));
        if (saturated !== due.sat) report_mismatch("saturated", 32'(due.sat), 32'(saturated));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    queue_opening_words();
    while (cmd_total < ITEM_TARGET) queue_random_phase();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (words_to_send.size() != 0 || word_loaded || conv_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
design/cnvr_pkg.sv
design/cnvr_ram.sv
design/cnvr_mac.sv
design/cnvr_seq.sv
design/conv2d_valid_multichannel_relu.sv
design/cnvr_check.sv
sim/tb_top.sv
